// ===== rtl/bsah_pkg.sv =====
// Shared types and constants of the binned SAH split finder.
package bsah_pkg;

  localparam int SCALE_W   = 21;
  localparam int SCALE_SH  = 16;
  localparam int COST_W    = 52;
  localparam int CFG_IDX_W = 3;
  localparam int AXES      = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_X   = 3'd0,
    REG_MIN_Y   = 3'd1,
    REG_MIN_Z   = 3'd2,
    REG_SCALE_X = 3'd3,
    REG_SCALE_Y = 3'd4,
    REG_SCALE_Z = 3'd5
  } cfg_reg_t;

  typedef enum logic [12:0] {
    S_IDLE    = 13'b0000000000001,
    S_BIN_RD  = 13'b0000000000010,
    S_BIN_WR  = 13'b0000000000100,
    S_AX      = 13'b0000000001000,
    S_SUF_RD  = 13'b0000000010000,
    S_SUF_ACC = 13'b0000000100000,
    S_PRE_RD  = 13'b0000001000000,
    S_PRE_ACC = 13'b0000010000000,
    S_COST    = 13'b0000100000000,
    S_CMP     = 13'b0001000000000,
    S_EMIT_L  = 13'b0010000000000,
    S_EMIT_R  = 13'b0100000000000,
    S_EMIT_NF = 13'b1000000000000
  } back_state_t;

endpackage

// ===== rtl/bsah_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module bsah_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/bsah_front.sv =====
// Front end: accept a triangle, compute its bin on each axis, hand it to the queue.
module bsah_front #(
  parameter int BIN_COUNT  = 16,
  parameter int COORD_BITS = 16
) (
  input  logic                                              clk,
  input  logic                                              rst_n,
  input  logic                                              start,
  output logic                                              busy,
  input  logic [2:0][COORD_BITS-1:0]                        cent,
  input  logic [2:0][COORD_BITS-1:0]                        lo,
  input  logic [2:0][COORD_BITS-1:0]                        hi,
  input  logic                                              last,
  input  logic [2:0][COORD_BITS-1:0]                        cmin,
  input  logic [2:0][bsah_pkg::SCALE_W-1:0]                 scale,
  input  logic                                              q_full,
  output logic                                              q_push,
  output logic [4+3*$clog2(BIN_COUNT)+6*COORD_BITS-1:0]     q_item
);
  import bsah_pkg::*;

  localparam int CW = COORD_BITS;
  localparam int BW = $clog2(BIN_COUNT);
  localparam int PW = CW + SCALE_W;

  typedef struct packed {
    logic                 last;
    logic [2:0]           en;
    logic [2:0][BW-1:0]   bin;
    logic [2:0][CW-1:0]   hi;
    logic [2:0][CW-1:0]   lo;
  } item_t;

  logic  fv_r, fv_nxt;
  item_t it_r, it_nxt;
  logic  accept;
  logic signed [CW:0] d [3];
  logic [PW-1:0] prod [3];
  logic [PW-1:0] q [3];

  assign busy   = fv_r && q_full;
  assign accept = start && !busy;
  assign q_push = fv_r && !q_full;
  assign q_item = it_r;

  always_comb begin
    it_nxt      = it_r;
    it_nxt.last = last;
    it_nxt.hi   = hi;
    it_nxt.lo   = lo;
    for (int k = 0; k < AXES; k++) begin
      d[k]    = $signed({cent[k][CW-1], cent[k]}) - $signed({cmin[k][CW-1], cmin[k]});
      prod[k] = PW'(d[k][CW-1:0]) * PW'(scale[k]);
      q[k]    = prod[k] >> SCALE_SH;
      it_nxt.en[k] = (scale[k] != '0);
      if (d[k][CW]) begin
        it_nxt.bin[k] = '0;
      end else if (q[k] > PW'(BIN_COUNT - 1)) begin
        it_nxt.bin[k] = BW'(BIN_COUNT - 1);
      end else begin
        it_nxt.bin[k] = q[k][BW-1:0];
      end
    end
  end

  always_comb begin
    fv_nxt = fv_r;
    if (accept) begin
      fv_nxt = 1'b1;
    end else if (q_push) begin
      fv_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= 1'b0;
    end else begin
      fv_r <= fv_nxt;
    end
    if (accept) begin
      it_r <= it_nxt;
    end
  end

endmodule

// ===== rtl/bsah_queue.sv =====
// Short FIFO between the binning front end and the back end.
module bsah_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic             empty,
  output logic [WIDTH-1:0] dout
);

  localparam int DEPTH = 4;
  localparam int PTR_W = $clog2(DEPTH);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PTR_W-1:0] wp_r, rp_r;
  logic [PTR_W:0]   cnt_r, cnt_nxt;

  assign full  = (cnt_r == (PTR_W+1)'(DEPTH));
  assign empty = (cnt_r == '0);
  assign dout  = slot_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wp_r <= wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= rp_r + 1'b1;
      end
    end
    if (push) begin
      slot_r[wp_r] <= din;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full && !pop |-> !push) else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    empty |-> !pop) else $error("queue pop while empty");
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop && !full |=> cnt_r == $past(cnt_r) + 1'b1) else $error("queue count");

endmodule

// ===== rtl/bsah_back.sv =====
// Back end: bin update, prefix/suffix sweeps, SAH cost search and result emission.
module bsah_back #(
  parameter int BIN_COUNT     = 16,
  parameter int COORD_BITS    = 16,
  parameter int MAX_TRIANGLES = 65536
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic                                          q_empty,
  input  logic [4+3*$clog2(BIN_COUNT)+6*COORD_BITS-1:0] q_item,
  output logic                                          q_pop,
  output logic                                          out_valid,
  output logic                                          out_found,
  output logic [1:0]                                    out_split_axis,
  output logic [$clog2(BIN_COUNT)-1:0]                  out_plane_bin,
  output logic [$clog2(MAX_TRIANGLES+1)-1:0]            out_tri_count,
  output logic [2:0][COORD_BITS-1:0]                    out_cmin,
  output logic [2:0][COORD_BITS-1:0]                    out_cmax,
  output logic [bsah_pkg::COST_W-1:0]                   out_split_cost,
  output logic                                          out_last_result
);
  import bsah_pkg::*;

  localparam int CW   = COORD_BITS;
  localparam int BW   = $clog2(BIN_COUNT);
  localparam int NW   = $clog2(MAX_TRIANGLES + 1);
  localparam int NB   = AXES * BIN_COUNT;
  localparam int AB   = $clog2(NB);
  localparam int RW   = NW + 6 * CW;
  localparam int AW   = 2 * CW + 3;
  localparam int MA   = (CW > NW) ? CW : NW;
  localparam int PW   = MA + AW;
  localparam int CSW  = PW + 1;
  localparam int LAST_STEP = 8;

  typedef struct packed {
    logic                 last;
    logic [2:0]           en;
    logic [2:0][BW-1:0]   bin;
    logic [2:0][CW-1:0]   hi;
    logic [2:0][CW-1:0]   lo;
  } item_t;

  typedef struct packed {
    logic [NW-1:0]        n;
    logic [2:0][CW-1:0]   hi;
    logic [2:0][CW-1:0]   lo;
  } rec_t;

  function automatic logic [NW-1:0] sat_add(logic [NW-1:0] a, logic [NW-1:0] b);
    logic [NW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s > (NW+1)'(MAX_TRIANGLES)) begin
      return NW'(MAX_TRIANGLES);
    end
    return s[NW-1:0];
  endfunction

  function automatic rec_t acc_add(rec_t a, rec_t b, logic bv);
    rec_t r;
    r = a;
    if (bv && b.n != '0) begin
      if (a.n == '0) begin
        r.lo = b.lo;
        r.hi = b.hi;
      end else begin
        for (int k = 0; k < AXES; k++) begin
          if ($signed(b.lo[k]) < $signed(a.lo[k])) r.lo[k] = b.lo[k];
          if ($signed(b.hi[k]) > $signed(a.hi[k])) r.hi[k] = b.hi[k];
        end
      end
      r.n = sat_add(a.n, b.n);
    end
    return r;
  endfunction

  function automatic logic [CW-1:0] extent(logic [CW-1:0] h, logic [CW-1:0] l);
    logic signed [CW:0] dd;
    dd = $signed({h[CW-1], h}) - $signed({l[CW-1], l});
    return (dd > 0) ? dd[CW-1:0] : '0;
  endfunction

  back_state_t st_r, st_nxt;
  item_t       it_r, it_nxt;
  logic [1:0]  axis_r, axis_nxt;
  logic [BW-1:0] s_r, s_nxt;
  logic [AB-1:0] ba_r, ba_nxt;
  logic [3:0]  mstep_r, mstep_nxt;
  rec_t        run_r, run_nxt, sf_r, sf_nxt;
  logic [AW-1:0] arl_r, arl_nxt, arr_r, arr_nxt;
  logic [PW-1:0] prod_r, prod_nxt;
  logic [CSW-1:0] cost_r, cost_nxt;
  logic        found_r, found_nxt;
  logic [1:0]  best_axis_r, best_axis_nxt;
  logic [BW-1:0] best_s_r, best_s_nxt;
  rec_t        best_l_r, best_l_nxt, best_r_r, best_r_nxt;
  logic [CSW-1:0] low_cost_r, low_cost_nxt;
  logic [NB-1:0] vld_r, vld_nxt;

  logic        ov_r, ov_nxt, of_r, of_nxt, olast_r, olast_nxt;
  logic [1:0]  oax_r, oax_nxt;
  logic [BW-1:0] obin_r, obin_nxt;
  rec_t        orec_r, orec_nxt;
  logic [COST_W-1:0] ocost_r, ocost_nxt;

  logic          bin_we;
  logic [AB-1:0] bin_raddr;
  rec_t          bin_wdata, bin_rdata;
  logic          suf_we;
  logic [BW-1:0] suf_raddr;
  rec_t          suf_rdata;
  rec_t          acc_res;
  rec_t          cur_bin;
  logic [MA-1:0] mul_a;
  logic [AW-1:0] mul_b;
  logic [AB-1:0] base_addr;

  bsah_ram #(.WIDTH(RW), .DEPTH(NB)) u_bin_ram (
    .clk   (clk),
    .we    (bin_we),
    .waddr (ba_r),
    .wdata (bin_wdata),
    .raddr (bin_raddr),
    .rdata (bin_rdata)
  );

  bsah_ram #(.WIDTH(RW), .DEPTH(BIN_COUNT)) u_suf_ram (
    .clk   (clk),
    .we    (suf_we),
    .waddr (s_r),
    .wdata (run_nxt),
    .raddr (suf_raddr),
    .rdata (suf_rdata)
  );

  assign base_addr = AB'(int'(axis_r) * BIN_COUNT);
  assign acc_res   = acc_add(run_r, bin_rdata, vld_r[ba_r]);

  // merge the current triangle into the bin just read
  always_comb begin
    cur_bin = bin_rdata;
    if (!vld_r[ba_r]) begin
      cur_bin.n  = NW'(1);
      cur_bin.lo = it_r.lo;
      cur_bin.hi = it_r.hi;
    end else begin
      cur_bin.n = sat_add(bin_rdata.n, NW'(1));
      for (int k = 0; k < AXES; k++) begin
        if ($signed(it_r.lo[k]) < $signed(bin_rdata.lo[k])) cur_bin.lo[k] = it_r.lo[k];
        if ($signed(it_r.hi[k]) > $signed(bin_rdata.hi[k])) cur_bin.hi[k] = it_r.hi[k];
      end
    end
  end

  // operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (mstep_r)
      4'd0: begin
        mul_a = MA'(extent(run_r.hi[0], run_r.lo[0]));
        mul_b = AW'(extent(run_r.hi[1], run_r.lo[1]));
      end
      4'd1: begin
        mul_a = MA'(extent(run_r.hi[0], run_r.lo[0]));
        mul_b = AW'(extent(run_r.hi[2], run_r.lo[2]));
      end
      4'd2: begin
        mul_a = MA'(extent(run_r.hi[1], run_r.lo[1]));
        mul_b = AW'(extent(run_r.hi[2], run_r.lo[2]));
      end
      4'd3: begin
        mul_a = MA'(extent(sf_r.hi[0], sf_r.lo[0]));
        mul_b = AW'(extent(sf_r.hi[1], sf_r.lo[1]));
      end
      4'd4: begin
        mul_a = MA'(extent(sf_r.hi[0], sf_r.lo[0]));
        mul_b = AW'(extent(sf_r.hi[2], sf_r.lo[2]));
      end
      4'd5: begin
        mul_a = MA'(extent(sf_r.hi[1], sf_r.lo[1]));
        mul_b = AW'(extent(sf_r.hi[2], sf_r.lo[2]));
      end
      4'd6: begin
        mul_a = MA'(run_r.n);
        mul_b = arl_r;
      end
      4'd7: begin
        mul_a = MA'(sf_r.n);
        mul_b = arr_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    st_nxt        = st_r;
    it_nxt        = it_r;
    axis_nxt      = axis_r;
    s_nxt         = s_r;
    ba_nxt        = ba_r;
    mstep_nxt     = mstep_r;
    run_nxt       = run_r;
    sf_nxt        = sf_r;
    arl_nxt       = arl_r;
    arr_nxt       = arr_r;
    prod_nxt      = prod_r;
    cost_nxt      = cost_r;
    found_nxt     = found_r;
    best_axis_nxt = best_axis_r;
    best_s_nxt    = best_s_r;
    best_l_nxt    = best_l_r;
    best_r_nxt    = best_r_r;
    low_cost_nxt  = low_cost_r;
    vld_nxt       = vld_r;
    ov_nxt        = 1'b0;
    of_nxt        = of_r;
    olast_nxt     = olast_r;
    oax_nxt       = oax_r;
    obin_nxt      = obin_r;
    orec_nxt      = orec_r;
    ocost_nxt     = ocost_r;
    q_pop         = 1'b0;
    bin_we        = 1'b0;
    bin_wdata     = cur_bin;
    bin_raddr     = base_addr + AB'(s_r);
    suf_we        = 1'b0;
    suf_raddr     = s_r + 1'b1;

    unique case (st_r)
      S_IDLE: begin
        if (!q_empty) begin
          q_pop    = 1'b1;
          it_nxt   = q_item;
          axis_nxt = '0;
          st_nxt   = S_BIN_RD;
        end
      end
      S_BIN_RD: begin
        bin_raddr = base_addr + AB'(it_r.bin[axis_r]);
        ba_nxt    = bin_raddr;
        if (it_r.en[axis_r]) begin
          st_nxt = S_BIN_WR;
        end else if (axis_r != 2'd2) begin
          axis_nxt = axis_r + 1'b1;
        end else begin
          axis_nxt  = '0;
          found_nxt = 1'b0;
          st_nxt    = it_r.last ? S_AX : S_IDLE;
        end
      end
      S_BIN_WR: begin
        bin_we         = 1'b1;
        vld_nxt[ba_r]  = 1'b1;
        if (axis_r != 2'd2) begin
          axis_nxt = axis_r + 1'b1;
          st_nxt   = S_BIN_RD;
        end else begin
          axis_nxt  = '0;
          found_nxt = 1'b0;
          st_nxt    = it_r.last ? S_AX : S_IDLE;
        end
      end
      S_AX: begin
        run_nxt = '0;
        s_nxt   = BW'(BIN_COUNT - 1);
        if (axis_r == 2'd3) begin
          st_nxt = found_r ? S_EMIT_L : S_EMIT_NF;
        end else if (it_r.en[axis_r]) begin
          st_nxt = S_SUF_RD;
        end else begin
          axis_nxt = axis_r + 1'b1;
        end
      end
      S_SUF_RD: begin
        ba_nxt = bin_raddr;
        st_nxt = S_SUF_ACC;
      end
      S_SUF_ACC: begin
        run_nxt = acc_res;
        suf_we  = 1'b1;
        if (s_r == BW'(1)) begin
          s_nxt  = '0;
          st_nxt = S_PRE_RD;
        end else begin
          s_nxt  = s_r - 1'b1;
          st_nxt = S_SUF_RD;
        end
      end
      S_PRE_RD: begin
        ba_nxt = bin_raddr;
        if (s_r == '0) begin
          run_nxt = '0;
        end
        st_nxt = S_PRE_ACC;
      end
      S_PRE_ACC: begin
        run_nxt = acc_res;
        sf_nxt  = suf_rdata;
        if (acc_res.n == '0 || suf_rdata.n == '0) begin
          if (s_r == BW'(BIN_COUNT - 2)) begin
            axis_nxt = axis_r + 1'b1;
            st_nxt   = S_AX;
          end else begin
            s_nxt  = s_r + 1'b1;
            st_nxt = S_PRE_RD;
          end
        end else begin
          mstep_nxt = '0;
          st_nxt    = S_COST;
        end
      end
      S_COST: begin
        prod_nxt  = PW'(mul_a) * PW'(mul_b);
        mstep_nxt = mstep_r + 1'b1;
        case (mstep_r) inside
          4'd0: begin
            arl_nxt = '0;
            arr_nxt = '0;
          end
          4'd1, 4'd2, 4'd3: arl_nxt = arl_r + (AW'(prod_r) << 1);
          4'd4, 4'd5, 4'd6: arr_nxt = arr_r + (AW'(prod_r) << 1);
          4'd7: cost_nxt = CSW'(prod_r);
          default: cost_nxt = cost_r + CSW'(prod_r);
        endcase
        if (mstep_r == 4'(LAST_STEP)) begin
          st_nxt = S_CMP;
        end
      end
      S_CMP: begin
        if (!found_r || cost_r < low_cost_r) begin
          found_nxt     = 1'b1;
          low_cost_nxt  = cost_r;
          best_axis_nxt = axis_r;
          best_s_nxt    = s_r;
          best_l_nxt    = run_r;
          best_r_nxt    = sf_r;
        end
        if (s_r == BW'(BIN_COUNT - 2)) begin
          axis_nxt = axis_r + 1'b1;
          st_nxt   = S_AX;
        end else begin
          s_nxt  = s_r + 1'b1;
          st_nxt = S_PRE_RD;
        end
      end
      S_EMIT_L: begin
        ov_nxt    = 1'b1;
        of_nxt    = 1'b1;
        olast_nxt = 1'b0;
        oax_nxt   = best_axis_r;
        obin_nxt  = best_s_r;
        orec_nxt  = best_l_r;
        ocost_nxt = COST_W'(low_cost_r);
        st_nxt    = S_EMIT_R;
      end
      S_EMIT_R: begin
        ov_nxt    = 1'b1;
        olast_nxt = 1'b1;
        orec_nxt  = best_r_r;
        vld_nxt   = '0;
        st_nxt    = S_IDLE;
      end
      S_EMIT_NF: begin
        ov_nxt    = 1'b1;
        of_nxt    = 1'b0;
        olast_nxt = 1'b1;
        oax_nxt   = '0;
        obin_nxt  = '0;
        orec_nxt  = '0;
        ocost_nxt = '0;
        vld_nxt   = '0;
        st_nxt    = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= S_IDLE;
      vld_r   <= '0;
      ov_r    <= 1'b0;
      found_r <= 1'b0;
      axis_r  <= '0;
    end else begin
      st_r    <= st_nxt;
      vld_r   <= vld_nxt;
      ov_r    <= ov_nxt;
      found_r <= found_nxt;
      axis_r  <= axis_nxt;
    end
    it_r        <= it_nxt;
    s_r         <= s_nxt;
    ba_r        <= ba_nxt;
    mstep_r     <= mstep_nxt;
    run_r       <= run_nxt;
    sf_r        <= sf_nxt;
    arl_r       <= arl_nxt;
    arr_r       <= arr_nxt;
    prod_r      <= prod_nxt;
    cost_r      <= cost_nxt;
    best_axis_r <= best_axis_nxt;
    best_s_r    <= best_s_nxt;
    best_l_r    <= best_l_nxt;
    best_r_r    <= best_r_nxt;
    low_cost_r  <= low_cost_nxt;
    of_r        <= of_nxt;
    olast_r     <= olast_nxt;
    oax_r       <= oax_nxt;
    obin_r      <= obin_nxt;
    orec_r      <= orec_nxt;
    ocost_r     <= ocost_nxt;
  end

  assign out_valid       = ov_r;
  assign out_found       = of_r;
  assign out_split_axis  = oax_r;
  assign out_plane_bin   = obin_r;
  assign out_tri_count   = orec_r.n;
  assign out_cmin        = orec_r.lo;
  assign out_cmax        = orec_r.hi;
  assign out_split_cost  = ocost_r;
  assign out_last_result = olast_r;

  a_pair: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_result |=> out_valid && out_last_result)
    else $error("left child not followed by right child");
  a_nf_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_last_result)
    else $error("not-found result must close the node");
  a_bins_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_result |-> vld_r == '0)
    else $error("bins not cleared after node");
  a_cost_steps: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == S_COST |-> mstep_r <= 4'(LAST_STEP))
    else $error("cost sequencer overran");

endmodule

// ===== rtl/binned_sah_split_finder_top.sv =====
// Top level of the binned SAH split finder: config registers, front, queue, back.
//
//  channel   direction  handshake               payload
//  in_*      in         start & !busy           centroid, triangle box, last_item
//  cfg_*     in         cfg_valid & cfg_ready   cfg_index, cfg_data
//  out_*     out        out_valid (one cycle)   child split fields
//
// The front end takes one request per cycle while the queue has room; busy rises
// only when the four-deep queue and the front stage are full.
// The back end pops each triangle, then reads and writes back its bin RAM entry on
// each enabled axis and leaves a disabled axis untouched. A last request then visits
// every axis and, per enabled axis, runs a suffix sweep (a read and an accumulate per
// bin), a prefix read and accumulate per plane and, on planes with both sides filled,
// nine shared multiplier steps and a compare; then one or two results are emitted.
// Reset clears control state and all bin valid bits at once. Results cannot be
// stalled: each shows on out_* for exactly one cycle.
module binned_sah_split_finder_top #(
  parameter int BIN_COUNT     = 16,
  parameter int COORD_BITS    = 16,
  parameter int MAX_TRIANGLES = 65536
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [COORD_BITS-1:0]                in_centroid_x,
  input  logic [COORD_BITS-1:0]                in_centroid_y,
  input  logic [COORD_BITS-1:0]                in_centroid_z,
  input  logic [COORD_BITS-1:0]                in_box_min_x,
  input  logic [COORD_BITS-1:0]                in_box_min_y,
  input  logic [COORD_BITS-1:0]                in_box_min_z,
  input  logic [COORD_BITS-1:0]                in_box_max_x,
  input  logic [COORD_BITS-1:0]                in_box_max_y,
  input  logic [COORD_BITS-1:0]                in_box_max_z,
  input  logic                                 in_last_item,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [bsah_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [bsah_pkg::SCALE_W-1:0]         cfg_data,
  output logic                                 out_valid,
  output logic                                 out_found,
  output logic [1:0]                           out_split_axis,
  output logic [$clog2(BIN_COUNT)-1:0]         out_plane_bin,
  output logic [$clog2(MAX_TRIANGLES+1)-1:0]   out_tri_count,
  output logic [COORD_BITS-1:0]                out_child_min_x,
  output logic [COORD_BITS-1:0]                out_child_min_y,
  output logic [COORD_BITS-1:0]                out_child_min_z,
  output logic [COORD_BITS-1:0]                out_child_max_x,
  output logic [COORD_BITS-1:0]                out_child_max_y,
  output logic [COORD_BITS-1:0]                out_child_max_z,
  output logic [bsah_pkg::COST_W-1:0]          out_split_cost,
  output logic                                 out_last_result
);
  import bsah_pkg::*;

  localparam int CW = COORD_BITS;
  localparam int IW = 4 + 3 * $clog2(BIN_COUNT) + 6 * CW;

  // configuration registers: per-axis centroid minimum and bin scale
  logic [2:0][CW-1:0]      cmin_r;
  logic [2:0][SCALE_W-1:0] scale_r;

  logic          q_full, q_push, q_empty, q_pop;
  logic [IW-1:0] q_din, q_dout;
  logic [2:0][CW-1:0] cmin_o, cmax_o;

  // registers take any write; idle-time writes only are promised
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmin_r  <= '0;
      scale_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MIN_X:   cmin_r[0]  <= cfg_data[CW-1:0];
        REG_MIN_Y:   cmin_r[1]  <= cfg_data[CW-1:0];
        REG_MIN_Z:   cmin_r[2]  <= cfg_data[CW-1:0];
        REG_SCALE_X: scale_r[0] <= cfg_data;
        REG_SCALE_Y: scale_r[1] <= cfg_data;
        REG_SCALE_Z: scale_r[2] <= cfg_data;
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  // front: classify each request into one bin per axis
  bsah_front #(.BIN_COUNT(BIN_COUNT), .COORD_BITS(COORD_BITS)) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .cent   ({in_centroid_z, in_centroid_y, in_centroid_x}),
    .lo     ({in_box_min_z, in_box_min_y, in_box_min_x}),
    .hi     ({in_box_max_z, in_box_max_y, in_box_max_x}),
    .last   (in_last_item),
    .cmin   (cmin_r),
    .scale  (scale_r),
    .q_full (q_full),
    .q_push (q_push),
    .q_item (q_din)
  );

  // queue: decouple binning from the slower bin update and evaluation
  bsah_queue #(.WIDTH(IW)) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_din),
    .full  (q_full),
    .pop   (q_pop),
    .empty (q_empty),
    .dout  (q_dout)
  );

  // back: update bins, sweep planes, emit children or a not-found result
  bsah_back #(
    .BIN_COUNT(BIN_COUNT), .COORD_BITS(COORD_BITS), .MAX_TRIANGLES(MAX_TRIANGLES)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_empty         (q_empty),
    .q_item          (q_dout),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_found       (out_found),
    .out_split_axis  (out_split_axis),
    .out_plane_bin   (out_plane_bin),
    .out_tri_count   (out_tri_count),
    .out_cmin        (cmin_o),
    .out_cmax        (cmax_o),
    .out_split_cost  (out_split_cost),
    .out_last_result (out_last_result)
  );

  assign out_child_min_x = cmin_o[0];
  assign out_child_min_y = cmin_o[1];
  assign out_child_min_z = cmin_o[2];
  assign out_child_max_x = cmax_o[0];
  assign out_child_max_y = cmax_o[1];
  assign out_child_max_z = cmax_o[2];

endmodule
